[hdl/rbis_pkg.sv]
package rbis_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] spin_x;
        logic signed [31:0] spin_y;
        logic signed [31:0] spin_z;
        logic [16:0]        step_time;
        logic               is_anchored;
        logic               can_rotate;
    } body_in_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] new_spin_x;
        logic signed [31:0] new_spin_y;
        logic signed [31:0] new_spin_z;
        logic signed [31:0] roll_step_deg;
        logic signed [31:0] pitch_step_deg;
        logic signed [31:0] yaw_step_deg;
    } body_out_t;

    localparam logic [1:0]  MODE_EULER    = 2'd0;
    localparam logic [1:0]  MODE_RK4      = 2'd1;
    localparam logic [1:0]  MODE_MIDPOINT = 2'd2;
    // Unassigned code: the body is not moved, damping and rotation still apply.
    localparam logic [1:0]  MODE_HOLD     = 2'd3;

    localparam logic [1:0]  ADDR_MODE     = 2'd0;
    localparam logic [1:0]  ADDR_GRAVITY  = 2'd1;
    localparam logic [1:0]  ADDR_GRAV_ON  = 2'd2;

    localparam logic signed [31:0] GRAVITY_RESET = -32'sd642252;
    localparam logic signed [17:0] DAMP_LIN      = 18'sd65405;
    localparam logic signed [17:0] DAMP_ANG      = 18'sd65208;
    localparam logic signed [19:0] ROT_DEG_K     = 20'sd375494;
    localparam logic [64:0]        SLEEP_LIMIT   = 65'd429497;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (v > hi)
            sat32 = 32'sh7FFFFFFF;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    // Round to nearest with ties toward positive infinity, then drop s bits.
    function automatic logic signed [71:0] rnd(input logic signed [71:0] v,
                                               input int unsigned s);
        logic signed [71:0] b;
        b = v + (72'sd1 <<< (s - 1));
        rnd = b >>> s;
    endfunction

endpackage

[hdl/rbis_axis.sv]
// One axis of the integration pipeline: move, damp, rotate scaling.
// Four register stages produce the damped values; two more turn the slept
// angular velocity into degrees. Valid bits are carried by the top level.
module rbis_axis (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] pos,
    input  logic signed [31:0] vel,
    input  logic signed [31:0] spin,
    input  logic signed [31:0] accel,
    input  logic [16:0]        dt,
    input  logic [1:0]         mode,
    output logic signed [31:0] pos_out,
    output logic signed [31:0] vel_out,
    output logic signed [31:0] spin_out,
    output logic [63:0]        vel_sq,
    output logic [63:0]        spin_sq,
    input  logic signed [31:0] spin_sleep,
    output logic signed [31:0] deg_out
);

    // Stage 1: a*dt, 2*v*dt, w*damp.
    logic signed [49:0] adt_raw_reg;
    logic signed [50:0] vdt2_reg;
    logic signed [49:0] wd_reg;
    logic signed [31:0] p1_reg, v1_reg;
    logic [16:0]        dt1_reg;
    logic [1:0]         m1_reg;
    // Stage 2: adt rounded, v' for Euler and RK, damped spin.
    logic signed [33:0] adt_reg;
    logic signed [31:0] ve_reg, vr_reg, p2_reg, w2_reg;
    logic signed [50:0] vdt2_2_reg;
    logic [16:0]        dt2_reg;
    logic [1:0]         m2_reg;
    // Stage 3: position products and the selected velocity.
    logic signed [50:0] vedt_reg, adtdt_reg, vdt2_3_reg;
    logic signed [31:0] vsel_reg, p3_reg, w3_reg;
    logic [1:0]         m3_reg;
    // Stage 4: final values.
    logic signed [31:0] p4_reg, vd_reg, w4_reg;

    logic signed [31:0] vsel_next;

    always_comb
    begin
        case (m2_reg)
            rbis_pkg::MODE_EULER:    vsel_next = ve_reg;
            default:                 vsel_next = vr_reg;
        endcase
    end

    logic signed [71:0] psum;
    always_comb
    begin
        case (m3_reg)
            rbis_pkg::MODE_EULER:
                psum = 72'(p3_reg) + rbis_pkg::rnd(72'(vedt_reg), 16);
            rbis_pkg::MODE_RK4, rbis_pkg::MODE_MIDPOINT:
                psum = 72'(p3_reg)
                     + rbis_pkg::rnd(72'(vdt2_3_reg) + 72'(adtdt_reg), 17);
            default:
                psum = 72'(p3_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adt_raw_reg <= 50'(accel) * $signed({1'b0, dt});
            vdt2_reg    <= 51'(vel) * $signed({1'b0, dt}) * 51'sd2;
            wd_reg      <= 50'(spin) * 50'(rbis_pkg::DAMP_ANG);
            p1_reg      <= pos;
            v1_reg      <= vel;
            dt1_reg     <= dt;
            m1_reg      <= mode;

            adt_reg    <= 34'(rbis_pkg::rnd(72'(adt_raw_reg), 16));
            ve_reg     <= rbis_pkg::sat32(72'(v1_reg)
                          + rbis_pkg::rnd(72'(adt_raw_reg), 16));
            vr_reg     <= (m1_reg == rbis_pkg::MODE_HOLD) ? v1_reg
                          : rbis_pkg::sat32(72'(v1_reg)
                          + rbis_pkg::rnd(72'(adt_raw_reg), 16));
            p2_reg     <= p1_reg;
            w2_reg     <= rbis_pkg::sat32(rbis_pkg::rnd(72'(wd_reg), 16));
            vdt2_2_reg <= vdt2_reg;
            dt2_reg    <= dt1_reg;
            m2_reg     <= m1_reg;

            vedt_reg   <= 51'(ve_reg) * $signed({1'b0, dt2_reg});
            adtdt_reg  <= 51'(adt_reg) * $signed({1'b0, dt2_reg});
            vdt2_3_reg <= vdt2_2_reg;
            vsel_reg   <= vsel_next;
            p3_reg     <= p2_reg;
            w3_reg     <= w2_reg;
            m3_reg     <= m2_reg;

            p4_reg <= rbis_pkg::sat32(psum);
            vd_reg <= rbis_pkg::sat32(rbis_pkg::rnd(
                          72'(50'(vsel_reg) * 50'(rbis_pkg::DAMP_LIN)), 16));
            w4_reg <= w3_reg;
        end
    end

    assign pos_out  = p4_reg;
    assign vel_out  = vd_reg;
    assign spin_out = w4_reg;
    assign vel_sq   = 64'(64'(vd_reg) * 64'(vd_reg));
    assign spin_sq  = 64'(64'(w4_reg) * 64'(w4_reg));

    // Rotation: two registered multiplies on the slept angular velocity,
    // which the top level registers after the stage 4 values.
    logic signed [49:0] wdt_reg;
    logic signed [55:0] deg_raw_reg;
    logic [16:0]        dt3_reg, dt4_reg, dt5_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dt3_reg     <= dt2_reg;
            dt4_reg     <= dt3_reg;
            dt5_reg     <= dt4_reg;
            wdt_reg     <= 50'(spin_sleep) * $signed({1'b0, dt5_reg});
            deg_raw_reg <= 56'(rbis_pkg::rnd(72'(wdt_reg), 16))
                         * 56'(rbis_pkg::ROT_DEG_K);
        end
    end
    assign deg_out = rbis_pkg::sat32(rbis_pkg::rnd(72'(deg_raw_reg), 16));

endmodule

[hdl/rigid_body_integration_step_core.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------
// body in  | start, busy            | body (rbis_pkg::body_in_t)
// result   | done (strobe, 1 cycle) | result (rbis_pkg::body_out_t)
// config   | APB psel/penable/pwrite| paddr, pwdata, prdata, pready
//
// A new transaction can enter on every cycle; busy is tied low. The path
// from the accepting edge to the done strobe runs through four stages for
// move and damping, one for the sleep test, two for the rotation multiplies
// and the output register.
// Reset clears the valid bits and done, and sets the configuration registers to their defaults.
// The receiver cannot stall, so the pipeline always advances.
module rigid_body_integration_step_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rbis_pkg::body_in_t  body,
    output logic                done,
    output rbis_pkg::body_out_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int DEPTH = 7;

    logic [1:0]         mode_reg;
    logic signed [31:0] gravity_reg;
    logic               grav_on_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // Configuration writes land at the completing access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rbis_pkg::MODE_EULER;
            gravity_reg <= rbis_pkg::GRAVITY_RESET;
            grav_on_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                rbis_pkg::ADDR_MODE:    mode_reg    <= pwdata[1:0];
                rbis_pkg::ADDR_GRAVITY: gravity_reg <= pwdata;
                rbis_pkg::ADDR_GRAV_ON: grav_on_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rbis_pkg::ADDR_MODE:    prdata = {30'd0, mode_reg};
            rbis_pkg::ADDR_GRAVITY: prdata = gravity_reg;
            rbis_pkg::ADDR_GRAV_ON: prdata = {31'd0, grav_on_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // Valid bits and side data travel alongside the axis pipelines.
    logic [DEPTH-1:0]   vld_reg;
    rbis_pkg::body_in_t side_reg [DEPTH];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DEPTH-2:0], start};
    end
    always_ff @(posedge clk)
    begin
        side_reg[0] <= body;
        for (int i = 1; i < DEPTH; i++)
            side_reg[i] <= side_reg[i-1];
    end

    logic signed [31:0] gy;
    assign gy = grav_on_reg ? gravity_reg : 32'sd0;

    logic signed [31:0] p_o [3];
    logic signed [31:0] v_o [3];
    logic signed [31:0] w_o [3];
    logic signed [31:0] w_s [3];
    logic signed [31:0] d_o [3];
    logic [63:0]        vq  [3];
    logic [63:0]        wq  [3];

    rbis_axis u_x (.clk, .en(1'b1), .pos(body.pos_x), .vel(body.vel_x),
        .spin(body.spin_x), .accel(32'sd0), .dt(body.step_time), .mode(mode_reg),
        .pos_out(p_o[0]), .vel_out(v_o[0]), .spin_out(w_o[0]), .vel_sq(vq[0]),
        .spin_sq(wq[0]), .spin_sleep(w_s[0]), .deg_out(d_o[0]));
    rbis_axis u_y (.clk, .en(1'b1), .pos(body.pos_y), .vel(body.vel_y),
        .spin(body.spin_y), .accel(gy), .dt(body.step_time), .mode(mode_reg),
        .pos_out(p_o[1]), .vel_out(v_o[1]), .spin_out(w_o[1]), .vel_sq(vq[1]),
        .spin_sq(wq[1]), .spin_sleep(w_s[1]), .deg_out(d_o[1]));
    rbis_axis u_z (.clk, .en(1'b1), .pos(body.pos_z), .vel(body.vel_z),
        .spin(body.spin_z), .accel(32'sd0), .dt(body.step_time), .mode(mode_reg),
        .pos_out(p_o[2]), .vel_out(v_o[2]), .spin_out(w_o[2]), .vel_sq(vq[2]),
        .spin_sq(wq[2]), .spin_sleep(w_s[2]), .deg_out(d_o[2]));

    // Stage 5: sleep test on the damped linear and angular velocities. The following stages only
    // hold the values until the rotation result is ready.
    logic               sleep;
    logic signed [31:0] p5_reg [3];
    logic signed [31:0] v5_reg [3];
    logic signed [31:0] w5_reg [3];
    logic signed [31:0] p6_reg [3];
    logic signed [31:0] v6_reg [3];
    logic signed [31:0] w6_reg [3];
    logic signed [31:0] p7_reg [3];
    logic signed [31:0] v7_reg [3];
    logic signed [31:0] w7_reg [3];
    assign sleep = (65'(vq[0]) + 65'(vq[1]) + 65'(vq[2]) < rbis_pkg::SLEEP_LIMIT)
                && (65'(wq[0]) + 65'(wq[1]) + 65'(wq[2]) < rbis_pkg::SLEEP_LIMIT);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p5_reg[i] <= p_o[i];
            v5_reg[i] <= sleep ? 32'sd0 : v_o[i];
            w5_reg[i] <= sleep ? 32'sd0 : w_o[i];
            p6_reg[i] <= p5_reg[i];
            v6_reg[i] <= v5_reg[i];
            w6_reg[i] <= w5_reg[i];
            p7_reg[i] <= p6_reg[i];
            v7_reg[i] <= v6_reg[i];
            w7_reg[i] <= w6_reg[i];
        end
    end
    assign w_s[0] = w5_reg[0];
    assign w_s[1] = w5_reg[1];
    assign w_s[2] = w5_reg[2];

    // Output register; anchored bodies and no-rotate bodies override.
    rbis_pkg::body_in_t sd;
    rbis_pkg::body_out_t res_reg;
    logic done_reg;
    assign sd = side_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (sd.is_anchored)
        begin
            res_reg <= {sd.pos_x, sd.pos_y, sd.pos_z, sd.vel_x, sd.vel_y, sd.vel_z,
                        sd.spin_x, sd.spin_y, sd.spin_z, 96'd0};
        end
        else
        begin
            res_reg <= {p7_reg[0], p7_reg[1], p7_reg[2], v7_reg[0], v7_reg[1],
                        v7_reg[2], w7_reg[0], w7_reg[1], w7_reg[2],
                        sd.can_rotate ? d_o[0] : 32'sd0,
                        sd.can_rotate ? d_o[1] : 32'sd0,
                        sd.can_rotate ? d_o[2] : 32'sd0};
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
